[hdl/eirc_pkg.sv]
// ----------------------------------------------------------------------------
// eirc_pkg
// shared types, codes and sizes of the ethernet / ipv4 receive classifier
// ----------------------------------------------------------------------------
package eirc_pkg;

	localparam int unsigned MAX_FRAME_LEN_DEF = 2048;
	localparam int unsigned COUNT_W           = 16;
	localparam int unsigned QUEUE_DEPTH       = 4;

	// frame layout
	localparam logic [15:0] ETH_LEN      = 16'd14;
	localparam logic [15:0] ARP_MIN_LEN  = 16'd42;
	localparam logic [15:0] IP_MIN_LEN   = 16'd34;
	localparam logic [5:0]  IPH_MIN      = 6'd20;
	localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
	localparam logic [15:0] ETYPE_ARP    = 16'h0806;
	localparam logic [3:0]  IHL_MASK     = 4'hF;

	localparam logic [7:0]  PROTO_ICMP   = 8'd1;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;

	// verdict codes
	localparam logic [2:0] VERDICT_DROP  = 3'd0;
	localparam logic [2:0] VERDICT_ARP   = 3'd1;
	localparam logic [2:0] VERDICT_ICMP  = 3'd2;
	localparam logic [2:0] VERDICT_UDP   = 3'd3;
	localparam logic [2:0] VERDICT_TCP   = 3'd4;
	localparam logic [2:0] VERDICT_OTHER = 3'd5;

	// drop reasons
	localparam logic [2:0] DROP_NONE       = 3'd0;
	localparam logic [2:0] DROP_SHORT_ETH  = 3'd1;
	localparam logic [2:0] DROP_SHORT_ARP  = 3'd2;
	localparam logic [2:0] DROP_ETHERTYPE  = 3'd3;
	localparam logic [2:0] DROP_SHORT_IP   = 3'd4;
	localparam logic [2:0] DROP_BAD_IHL    = 3'd5;
	localparam logic [2:0] DROP_BAD_TOTLEN = 3'd6;
	localparam logic [2:0] DROP_NOT_US     = 3'd7;

	// configuration register word index
	localparam logic REG_LOCAL_IP = 1'b0;

	// everything the back end needs to classify one finished frame
	typedef struct packed {
		logic [15:0] frame_len;
		logic [15:0] ether_type;
		logic [3:0]  header_words;
		logic [15:0] total_length;
		logic [7:0]  protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [47:0] src_mac;
		logic [31:0] frame_number;
	} frame_sum_t;

endpackage

[hdl/eirc_front.sv]
// ----------------------------------------------------------------------------
// eirc_front
// byte-wise header capture, one frame summary pushed per last byte
// ----------------------------------------------------------------------------
module eirc_front
	import eirc_pkg::*;
#(
	parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_accept,
	input  logic [7:0]       frame_byte,
	input  logic             last_byte,
	output logic             push,
	output frame_sum_t       push_sum
);

	localparam logic [COUNT_W-1:0] MAX_LEN = COUNT_W'(MAX_FRAME_LEN);

	logic [COUNT_W-1:0] count_q;
	logic [15:0]        etype_q;
	logic [3:0]         hwords_q;
	logic [15:0]        totlen_q;
	logic [7:0]         proto_q;
	logic [31:0]        src_ip_q;
	logic [31:0]        dst_ip_q;
	logic [47:0]        mac_q;
	logic [31:0]        frames_q;

	logic [15:0]        etype_n;
	logic [3:0]         hwords_n;
	logic [15:0]        totlen_n;
	logic [7:0]         proto_n;
	logic [31:0]        src_ip_n;
	logic [31:0]        dst_ip_n;
	logic [47:0]        mac_n;
	logic [COUNT_W-1:0] count_n;

	// field capture by byte position (position is the count before this word)
	always_comb begin
		mac_n    = mac_q;
		etype_n  = etype_q;
		hwords_n = hwords_q;
		totlen_n = totlen_q;
		proto_n  = proto_q;
		src_ip_n = src_ip_q;
		dst_ip_n = dst_ip_q;
		if (count_q >= 16'd6 && count_q <= 16'd11) begin
			mac_n = {mac_q[39:0], frame_byte};
		end else if (count_q == 16'd12 || count_q == 16'd13) begin
			etype_n = {etype_q[7:0], frame_byte};
		end else if (count_q == 16'd14) begin
			hwords_n = frame_byte[3:0] & IHL_MASK;
		end else if (count_q == 16'd16 || count_q == 16'd17) begin
			totlen_n = {totlen_q[7:0], frame_byte};
		end else if (count_q == 16'd23) begin
			proto_n = frame_byte;
		end else if (count_q >= 16'd26 && count_q <= 16'd29) begin
			src_ip_n = {src_ip_q[23:0], frame_byte};
		end else if (count_q >= 16'd30 && count_q <= 16'd33) begin
			dst_ip_n = {dst_ip_q[23:0], frame_byte};
		end
		// saturating length
		count_n = (count_q < MAX_LEN) ? count_q + 1'b1 : count_q;
	end

	assign push = byte_accept && last_byte;

	always_comb begin
		push_sum.frame_len    = count_n;
		push_sum.ether_type   = etype_n;
		push_sum.header_words = hwords_n;
		push_sum.total_length = totlen_n;
		push_sum.protocol     = proto_n;
		push_sum.src_ip       = src_ip_n;
		push_sum.dst_ip       = dst_ip_n;
		push_sum.src_mac      = mac_n;
		push_sum.frame_number = frames_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			etype_q  <= '0;
			hwords_q <= '0;
			totlen_q <= '0;
			proto_q  <= '0;
			src_ip_q <= '0;
			dst_ip_q <= '0;
			mac_q    <= '0;
			frames_q <= '0;
		end else if (byte_accept) begin
			if (last_byte) begin
				// fresh start for the next frame
				count_q  <= '0;
				etype_q  <= '0;
				hwords_q <= '0;
				totlen_q <= '0;
				proto_q  <= '0;
				src_ip_q <= '0;
				dst_ip_q <= '0;
				mac_q    <= '0;
				frames_q <= frames_q + 32'd1;
			end else begin
				count_q  <= count_n;
				etype_q  <= etype_n;
				hwords_q <= hwords_n;
				totlen_q <= totlen_n;
				proto_q  <= proto_n;
				src_ip_q <= src_ip_n;
				dst_ip_q <= dst_ip_n;
				mac_q    <= mac_n;
			end
		end
	end

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_LEN)
		else $error("byte count above max frame length");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (count_q == '0) && (mac_q == '0) && (dst_ip_q == '0))
		else $error("captures not cleared after last byte");

	a_frame_count: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> frames_q == $past(frames_q) + 32'd1)
		else $error("frame counter did not advance");

endmodule

[hdl/eirc_fifo.sv]
// ----------------------------------------------------------------------------
// eirc_fifo
// short queue of frame summaries between front and back end
// ----------------------------------------------------------------------------
module eirc_fifo
	import eirc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_sum_t push_sum,
	input  logic       pop,
	output frame_sum_t head_sum,
	output logic       empty,
	output logic       full
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

	frame_sum_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == DEPTH_CNT);
	assign head_sum = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("summary queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("summary queue underflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_CNT)
		else $error("queue count out of range");

endmodule

[hdl/eirc_back.sv]
// ----------------------------------------------------------------------------
// eirc_back
// frame classification and registered result word
// ----------------------------------------------------------------------------
module eirc_back
	import eirc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] local_ip,
	input  frame_sum_t  head_sum,
	input  logic        empty,
	output logic        pop,
	input  logic        result_ready,
	output logic        result_valid,
	output logic [2:0]  verdict,
	output logic [2:0]  drop_reason,
	output logic        learn_valid,
	output logic [31:0] source_ip,
	output logic [31:0] dest_ip,
	output logic [47:0] source_mac,
	output logic [6:0]  payload_offset,
	output logic [15:0] payload_length,
	output logic [31:0] frame_number
);

	logic [5:0]  hdr;
	logic [15:0] hdr16;
	logic [16:0] ip_end;
	logic [2:0]  verdict_c;
	logic [2:0]  reason_c;
	logic        learn_c;
	logic [6:0]  poff_c;
	logic [15:0] plen_c;
	logic        valid_q;

	assign hdr    = {head_sum.header_words, 2'b00};
	assign hdr16  = {10'd0, hdr};
	assign ip_end = {1'b0, ETH_LEN} + {1'b0, head_sum.total_length};

	// check order follows the header layout: eth, arp, ethertype, ip
	always_comb begin
		verdict_c = VERDICT_DROP;
		reason_c  = DROP_NONE;
		learn_c   = 1'b0;
		poff_c    = '0;
		plen_c    = '0;
		if (head_sum.frame_len < ETH_LEN) begin
			reason_c = DROP_SHORT_ETH;
		end else if (head_sum.ether_type == ETYPE_ARP) begin
			if (head_sum.frame_len >= ARP_MIN_LEN) begin
				verdict_c = VERDICT_ARP;
			end else begin
				reason_c = DROP_SHORT_ARP;
			end
		end else if (head_sum.ether_type != ETYPE_IPV4) begin
			reason_c = DROP_ETHERTYPE;
		end else if (head_sum.frame_len < IP_MIN_LEN) begin
			reason_c = DROP_SHORT_IP;
		end else if (hdr < IPH_MIN) begin
			reason_c = DROP_BAD_IHL;
		end else if (head_sum.frame_len < ETH_LEN + hdr16) begin
			reason_c = DROP_SHORT_IP;
		end else if (head_sum.total_length < hdr16 || ip_end > {1'b0, head_sum.frame_len}) begin
			reason_c = DROP_BAD_TOTLEN;
		end else if (head_sum.dst_ip != local_ip) begin
			reason_c = DROP_NOT_US;
		end else begin
			learn_c = 1'b1;
			poff_c  = 7'(ETH_LEN) + {1'b0, hdr};
			plen_c  = head_sum.total_length - hdr16;
			case (head_sum.protocol)
				PROTO_ICMP: verdict_c = VERDICT_ICMP;
				PROTO_UDP:  verdict_c = VERDICT_UDP;
				PROTO_TCP:  verdict_c = VERDICT_TCP;
				default:    verdict_c = VERDICT_OTHER;
			endcase
		end
	end

	// load the result register when it is free or being emptied
	assign pop          = !empty && (!valid_q || result_ready);
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict        <= verdict_c;
			drop_reason    <= reason_c;
			learn_valid    <= learn_c;
			source_ip      <= head_sum.src_ip;
			dest_ip        <= head_sum.dst_ip;
			source_mac     <= head_sum.src_mac;
			payload_offset <= poff_c;
			payload_length <= plen_c;
			frame_number   <= head_sum.frame_number;
		end
	end

	a_learn_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && learn_valid |-> drop_reason == DROP_NONE &&
			(verdict == VERDICT_ICMP || verdict == VERDICT_UDP ||
			 verdict == VERDICT_TCP || verdict == VERDICT_OTHER))
		else $error("learn flag on a non-ip verdict");

	a_drop_has_reason: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && verdict == VERDICT_DROP |-> drop_reason != DROP_NONE)
		else $error("dropped frame without reason");

	a_hold_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(frame_number))
		else $error("stalled result changed");

endmodule

[hdl/eth_ipv4_rx_classifier_top.sv]
// ----------------------------------------------------------------------------
// eth_ipv4_rx_classifier_top
// ethernet / ipv4 receive classifier with apb configuration
// ----------------------------------------------------------------------------
// frame bytes stream in at one word per clock while frame_ready is high, from
// the destination mac on, last_byte marking the end of a frame. a byte is
// accepted when frame_valid and frame_ready are both high; frame_ready only
// drops when the four-entry frame summary queue is full, which happens only
// when the result side stalls across several frames. one result word
// per frame appears after its last byte has passed through the queue and then
// the classification register, when that register can take it. configure
// local_ip over apb at word 0 while no frame is in flight.
// ----------------------------------------------------------------------------
module eth_ipv4_rx_classifier_top
	import eirc_pkg::*;
#(
	parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// frame byte stream
	input  logic        frame_valid,
	output logic        frame_ready,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	// classification results
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  verdict,
	output logic [2:0]  drop_reason,
	output logic        learn_valid,
	output logic [31:0] source_ip,
	output logic [31:0] dest_ip,
	output logic [47:0] source_mac,
	output logic [6:0]  payload_offset,
	output logic [15:0] payload_length,
	output logic [31:0] frame_number
);

	logic [31:0] local_ip_q;
	logic        cfg_write;
	logic        byte_accept;
	logic        push;
	logic        pop;
	logic        q_empty;
	logic        q_full;
	frame_sum_t  push_sum;
	frame_sum_t  head_sum;

	// apb: zero wait states, word index in paddr[2], byte lanes ignored
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_LOCAL_IP);
	assign prdata    = (paddr[2] == REG_LOCAL_IP) ? local_ip_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
		end else if (cfg_write) begin
			local_ip_q <= pwdata;
		end
	end

	// input stalls whenever the frame summary queue is full
	assign frame_ready = !q_full;
	assign byte_accept = frame_valid && frame_ready;

	// front end: per-byte header capture
	eirc_front #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_accept(byte_accept),
		.frame_byte (frame_byte),
		.last_byte  (last_byte),
		.push       (push),
		.push_sum   (push_sum)
	);

	// decoupling queue of finished frame summaries
	eirc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_sum(push_sum),
		.pop     (pop),
		.head_sum(head_sum),
		.empty   (q_empty),
		.full    (q_full)
	);

	// back end: verdict, drop reason, learn data
	eirc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.local_ip      (local_ip_q),
		.head_sum      (head_sum),
		.empty         (q_empty),
		.pop           (pop),
		.result_ready  (result_ready),
		.result_valid  (result_valid),
		.verdict       (verdict),
		.drop_reason   (drop_reason),
		.learn_valid   (learn_valid),
		.source_ip     (source_ip),
		.dest_ip       (dest_ip),
		.source_mac    (source_mac),
		.payload_offset(payload_offset),
		.payload_length(payload_length),
		.frame_number  (frame_number)
	);

endmodule

[sim/eth_ipv4_rx_classifier_top_tb.sv]
// ----------------------------------------------------------------------------
// eth_ipv4_rx_classifier_top_tb
// self-checking bench for the ethernet / ipv4 receive classifier
// ----------------------------------------------------------------------------
// frames go in one byte word at a time, every byte is run through a local
// classifier model. every result word is compared field by field with
// the oldest pending verdict. directed frames hit each drop reason and
// verdict, then random traffic runs under several local addresses and result
// pacing styles, followed by a long result hold-off.
// ----------------------------------------------------------------------------
module eth_ipv4_rx_classifier_top_tb;
	import eirc_pkg::*;

	localparam int unsigned MAX_LEN      = MAX_FRAME_LEN_DEF;
	localparam int unsigned HOLD_CYCLES  = 300;  // long result hold-off
	localparam int unsigned QUIET_LIMIT  = 5000; // cycles with no handshake at all
	localparam int unsigned DRAIN_CYCLES = 8;    // extra wait after the last verdict has come back
	localparam logic [2:0]  LOCAL_IP_ADDR = {REG_LOCAL_IP, 2'b00};

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_pace_t;

	// one classification word as the block should report it
	typedef struct packed {
		logic [2:0]  verdict;
		logic [2:0]  drop_reason;
		logic        learn;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [47:0] src_mac;
		logic [6:0]  offset;
		logic [15:0] length;
		logic [31:0] number;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        frame_valid;
	logic        frame_ready;
	logic [7:0]  frame_byte;
	logic        last_byte;
	logic        result_valid;
	logic        result_ready;
	logic [2:0]  verdict;
	logic [2:0]  drop_reason;
	logic        learn_valid;
	logic [31:0] source_ip;
	logic [31:0] dest_ip;
	logic [47:0] source_mac;
	logic [6:0]  payload_offset;
	logic [15:0] payload_length;
	logic [31:0] frame_number;

	eth_ipv4_rx_classifier_top #(
		.MAX_FRAME_LEN(MAX_LEN)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.frame_valid   (frame_valid),
		.frame_ready   (frame_ready),
		.frame_byte    (frame_byte),
		.last_byte     (last_byte),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.verdict       (verdict),
		.drop_reason   (drop_reason),
		.learn_valid   (learn_valid),
		.source_ip     (source_ip),
		.dest_ip       (dest_ip),
		.source_mac    (source_mac),
		.payload_offset(payload_offset),
		.payload_length(payload_length),
		.frame_number  (frame_number)
	);

	// ------------------------------------------------------------------------
	// classifier model state: per-frame captures plus the frame counter
	// ------------------------------------------------------------------------
	logic [15:0] rx_count       = '0;
	logic [15:0] rx_etype       = '0;
	logic [3:0]  rx_ihl         = '0;
	logic [15:0] rx_totlen      = '0;
	logic [7:0]  rx_proto       = '0;
	logic [31:0] rx_src_ip      = '0;
	logic [31:0] rx_dst_ip      = '0;
	logic [47:0] rx_src_mac     = '0;
	logic [31:0] frames_counted = '0;
	logic [31:0] own_ip         = '0;   // mirrors the local_ip register

	verdict_t    pending_verdicts[$];
	logic [7:0]  frame_buf[$];

	int unsigned failures        = 0;
	int unsigned results_checked = 0;
	int unsigned words_sent      = 0;
	int unsigned configs_written = 0;
	int unsigned verdict_hits[8] = '{default: 0};
	int unsigned drop_hits[8]    = '{default: 0};

	// sender and receiver pacing
	bit          tx_gaps;
	int unsigned burst_left;
	rx_pace_t    rx_pace;
	bit          hold_req;

	// ------------------------------------------------------------------------
	// model: capture one accepted byte, classify on the last one
	// ------------------------------------------------------------------------
	function automatic void classify_byte(input logic [7:0] b, input logic eof);
		int unsigned pos;
		int unsigned len;
		int unsigned hdr;
		int unsigned tot;
		verdict_t    v;
		pos = rx_count;
		// header fields land at fixed byte positions
		if (pos >= 6 && pos <= 11) rx_src_mac = {rx_src_mac[39:0], b};
		else if (pos == 12 || pos == 13) rx_etype = {rx_etype[7:0], b};
		else if (pos == 14) rx_ihl = b[3:0] & IHL_MASK;
		else if (pos == 16 || pos == 17) rx_totlen = {rx_totlen[7:0], b};
		else if (pos == 23) rx_proto = b;
		else if (pos >= 26 && pos <= 29) rx_src_ip = {rx_src_ip[23:0], b};
		else if (pos >= 30 && pos <= 33) rx_dst_ip = {rx_dst_ip[23:0], b};
		// length saturates, so oversize frames look exactly max length
		if (rx_count < MAX_LEN) rx_count++;
		if (!eof) return;

		frames_counted++;
		len = rx_count;
		hdr = rx_ihl * 4;
		tot = rx_totlen;
		v = '0;
		v.verdict     = VERDICT_DROP;
		v.drop_reason = DROP_NONE;
		// first failing check wins
		if (len < ETH_LEN) begin
			v.drop_reason = DROP_SHORT_ETH;
		end else if (rx_etype == ETYPE_ARP) begin
			if (len >= ARP_MIN_LEN) v.verdict = VERDICT_ARP;
			else v.drop_reason = DROP_SHORT_ARP;
		end else if (rx_etype != ETYPE_IPV4) begin
			v.drop_reason = DROP_ETHERTYPE;
		end else if (len < IP_MIN_LEN) begin
			v.drop_reason = DROP_SHORT_IP;
		end else if (hdr < IPH_MIN) begin
			v.drop_reason = DROP_BAD_IHL;
		end else if (len < ETH_LEN + hdr) begin
			v.drop_reason = DROP_SHORT_IP;
		end else if (tot < hdr || ETH_LEN + tot > len) begin
			v.drop_reason = DROP_BAD_TOTLEN;
		end else if (rx_dst_ip != own_ip) begin
			v.drop_reason = DROP_NOT_US;
		end else begin
			v.learn  = 1'b1;
			v.offset = 7'(ETH_LEN + hdr);
			v.length = 16'(tot - hdr);
			case (rx_proto)
				PROTO_ICMP: v.verdict = VERDICT_ICMP;
				PROTO_UDP:  v.verdict = VERDICT_UDP;
				PROTO_TCP:  v.verdict = VERDICT_TCP;
				default:    v.verdict = VERDICT_OTHER;
			endcase
		end
		// addresses are reported whatever the verdict
		v.src_ip  = rx_src_ip;
		v.dst_ip  = rx_dst_ip;
		v.src_mac = rx_src_mac;
		v.number  = frames_counted;
		pending_verdicts.push_back(v);
		verdict_hits[v.verdict]++;
		drop_hits[v.drop_reason]++;

		// next frame starts from clean captures
		rx_count   = '0;
		rx_etype   = '0;
		rx_ihl     = '0;
		rx_totlen  = '0;
		rx_proto   = '0;
		rx_src_ip  = '0;
		rx_dst_ip  = '0;
		rx_src_mac = '0;
	endfunction

	// ------------------------------------------------------------------------
	// frame builder: random filler with the header fields placed on top,
	// cut to the requested length
	// ------------------------------------------------------------------------
	function automatic void build_frame(input logic [15:0] etype, input logic [7:0] vihl,
			input logic [15:0] totlen, input logic [7:0] proto, input logic [31:0] dst,
			input int unsigned flen);
		logic [7:0] b;
		frame_buf.delete();
		for (int unsigned i = 0; i < flen; i++) begin
			b = 8'($urandom);
			case (i)
				12: b = etype[15:8];
				13: b = etype[7:0];
				14: b = vihl;
				16: b = totlen[15:8];
				17: b = totlen[7:0];
				23: b = proto;
				30: b = dst[31:24];
				31: b = dst[23:16];
				32: b = dst[15:8];
				33: b = dst[7:0];
				default: ;
			endcase
			frame_buf.push_back(b);
		end
	endfunction

	function automatic logic [7:0] pick_proto();
		case ($urandom_range(0, 4))
			0:       return PROTO_ICMP;
			1:       return PROTO_UDP;
			2:       return PROTO_TCP;
			default: return 8'($urandom);
		endcase
	endfunction

	// version nibble is ignored by the block, so vary it now and then
	function automatic logic [3:0] pick_version();
		return ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd4;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// sender: one byte word per call, bursts of random length with gaps
	// ------------------------------------------------------------------------
	task automatic send_word(input logic [7:0] b, input logic eof);
		int unsigned gap;
		frame_valid <= 1'b1;
		frame_byte  <= b;
		last_byte   <= eof;
		do @(posedge clk); while (!frame_ready);
		classify_byte(b, eof);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// burst over: maybe idle a little, now and then a longer pause
			burst_left = $urandom_range(0, 40);
			gap = tx_gaps ? $urandom_range(0, ($urandom_range(0, 7) == 0) ? 20 : 4) : 0;
			if (gap > 0) begin
				frame_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_word(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	task automatic send_built(input logic [15:0] etype, input logic [7:0] vihl,
			input logic [15:0] totlen, input logic [7:0] proto, input logic [31:0] dst,
			input int unsigned flen);
		build_frame(etype, vihl, totlen, proto, dst, flen);
		send_frame();
	endtask

	// stop offering bytes until every pending verdict has come back
	task automatic drain_results();
		frame_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write of local_ip, only with the block idle
	task automatic write_local_ip(input logic [31:0] value);
		drain_results();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LOCAL_IP_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		own_ip = value;
		configs_written++;
	endtask

	// one random frame, mostly well formed ipv4 for us, the rest broken or noise
	task automatic random_frame();
		int unsigned kind;
		int unsigned ihl;
		int unsigned hdr;
		int unsigned tot;
		int unsigned flen;
		kind = $urandom_range(0, 99);
		ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
		hdr  = ihl * 4;
		tot  = hdr + $urandom_range(0, 24);
		flen = 14 + tot + $urandom_range(0, 4);
		if (kind < 60) begin
			build_frame(ETYPE_IPV4, {pick_version(), 4'(ihl)}, 16'(tot), pick_proto(),
				own_ip, flen);
		end else if (kind < 68) begin
			// arp, both sides of the minimum length
			build_frame(ETYPE_ARP, 8'($urandom), 16'($urandom), 8'($urandom),
				32'($urandom), $urandom_range(14, 64));
		end else if (kind < 73) begin
			build_frame(16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
				32'($urandom), $urandom_range(14, 64));
		end else if (kind < 78) begin
			// shorter than the ethernet header
			build_frame(ETYPE_IPV4, 8'h45, 16'd20, PROTO_UDP, own_ip, $urandom_range(1, 13));
		end else if (kind < 82) begin
			build_frame(ETYPE_IPV4, {pick_version(), 4'($urandom_range(0, 4))}, 16'(tot),
				pick_proto(), own_ip, $urandom_range(34, 70));
		end else if (kind < 86) begin
			// cut inside the minimum or the option-extended ip header
			if ($urandom_range(0, 1) == 0) begin
				flen = $urandom_range(14, 33);
			end else begin
				ihl  = $urandom_range(6, 15);
				flen = $urandom_range(34, 13 + ihl * 4);
			end
			build_frame(ETYPE_IPV4, {pick_version(), 4'(ihl)}, 16'(ihl * 4), pick_proto(),
				own_ip, flen);
		end else if (kind < 91) begin
			// total length below the header or beyond the frame
			if ($urandom_range(0, 1) == 0) tot = $urandom_range(0, hdr - 1);
			else tot = flen - 14 + $urandom_range(1, 40);
			build_frame(ETYPE_IPV4, {pick_version(), 4'(ihl)}, 16'(tot), pick_proto(),
				own_ip, flen);
		end else if (kind < 96) begin
			build_frame(ETYPE_IPV4, {pick_version(), 4'(ihl)}, 16'(tot), pick_proto(),
				own_ip ^ (32'h1 << $urandom_range(0, 31)), flen);
		end else begin
			build_frame(16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
				32'($urandom), $urandom_range(1, 80));
		end
		send_frame();
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// one frame per drop reason and per verdict, plus the length edges
	task automatic test_directed();
		rx_pace = RX_ALWAYS;
		tx_gaps = 1'b0;
		// local_ip still at its reset value of zero
		send_built(ETYPE_IPV4, 8'h45, 16'd20, PROTO_ICMP, 32'h0, 34);
		write_local_ip(32'hC0A8_0117);
		// single-byte frames with both byte extremes
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		send_built(ETYPE_IPV4, 8'h45, 16'd20, PROTO_UDP, own_ip, 13);
		send_built(ETYPE_IPV4, 8'h45, 16'd20, PROTO_UDP, own_ip, 14);
		// arp one byte short, exactly minimum, padded
		send_built(ETYPE_ARP, 8'h00, 16'd0, 8'h00, 32'h0, 41);
		send_built(ETYPE_ARP, 8'h00, 16'd0, 8'h00, 32'h0, 42);
		send_built(ETYPE_ARP, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 60);
		send_built(16'h86DD, 8'h45, 16'd20, PROTO_TCP, own_ip, 60);
		send_built(ETYPE_IPV4, 8'h45, 16'd20, PROTO_TCP, own_ip, 33);
		// header length nibble of zero and just below the minimum
		send_built(ETYPE_IPV4, 8'h40, 16'd20, PROTO_TCP, own_ip, 60);
		send_built(ETYPE_IPV4, 8'h44, 16'd20, PROTO_TCP, own_ip, 60);
		// largest header: one byte short, then exact with empty payload
		send_built(ETYPE_IPV4, 8'h4F, 16'd60, PROTO_ICMP, own_ip, 73);
		send_built(ETYPE_IPV4, 8'h4F, 16'd60, PROTO_ICMP, own_ip, 74);
		// total length below header, one past frame, widest value
		send_built(ETYPE_IPV4, 8'h45, 16'd19, PROTO_UDP, own_ip, 60);
		send_built(ETYPE_IPV4, 8'h45, 16'd21, PROTO_UDP, own_ip, 34);
		send_built(ETYPE_IPV4, 8'h45, 16'hFFFF, PROTO_UDP, own_ip, 60);
		// accepted with udp, tcp and other protocols
		send_built(ETYPE_IPV4, 8'h45, 16'd20, PROTO_UDP, own_ip, 34);
		send_built(ETYPE_IPV4, 8'h45, 16'd40, PROTO_TCP, own_ip, 60);
		send_built(ETYPE_IPV4, 8'h46, 16'd30, 8'hFF, own_ip, 44);
		send_built(ETYPE_IPV4, 8'h45, 16'd26, 8'h00, own_ip, 40);
		// destination off by one bit and fully inverted
		send_built(ETYPE_IPV4, 8'h45, 16'd20, PROTO_ICMP, own_ip ^ 32'h1, 34);
		send_built(ETYPE_IPV4, 8'h45, 16'd20, PROTO_ICMP, ~own_ip, 34);
		// odd version nibble still accepted
		send_built(ETYPE_IPV4, 8'hF5, 16'd28, PROTO_UDP, own_ip, 42);
	endtask

	task automatic test_random_traffic(input logic [31:0] addr, input rx_pace_t pace,
			input bit gaps, input int unsigned byte_goal);
		int unsigned first_word;
		write_local_ip(addr);
		rx_pace    = pace;
		tx_gaps    = gaps;
		first_word = words_sent;
		while (words_sent - first_word < byte_goal)
			random_frame();
	endtask

	// receiver holds off while short frames keep coming, so the summary
	// queue fills and frame_ready has to drop
	task automatic test_result_backpressure();
		drain_results();
		rx_pace  = RX_ALWAYS;
		tx_gaps  = 1'b0;
		hold_req = 1'b1;
		repeat (24) begin
			build_frame(16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
				32'($urandom), $urandom_range(1, 16));
			send_frame();
		end
		// sender waits for every verdict before going on
		drain_results();
	endtask

	// ------------------------------------------------------------------------
	// clock, receiver, checker, watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result_ready pacing; a hold request parks it low for a long stretch
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			case (rx_pace)
				RX_ALWAYS: result_ready <= 1'b1;
				RX_RANDOM: result_ready <= ($urandom_range(0, 3) != 0);
				default: begin
					// mostly ready, with occasional stall runs
					if (stall_left > 0) begin
						stall_left--;
						result_ready <= 1'b0;
					end else if ($urandom_range(0, 15) == 0) begin
						stall_left = $urandom_range(1, 30);
						result_ready <= 1'b0;
					end else begin
						result_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// every accepted result word against the oldest pending verdict
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result word with no frame pending: verdict %0d, frame_number %0d",
					verdict, frame_number);
				failures++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("verdict", want.verdict, verdict);
				check_field("drop_reason", want.drop_reason, drop_reason);
				check_field("learn_valid", want.learn, learn_valid);
				check_field("source_ip", want.src_ip, source_ip);
				check_field("dest_ip", want.dst_ip, dest_ip);
				check_field("source_mac", want.src_mac, source_mac);
				check_field("payload_offset", want.offset, payload_offset);
				check_field("payload_length", want.length, payload_length);
				check_field("frame_number", want.number, frame_number);
				results_checked++;
			end
		end
	end

	// give up when nothing moves on any port for too long
	always @(posedge clk) begin
		int unsigned quiet_cycles;
		if ((frame_valid && frame_ready) || (result_valid && result_ready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles, %0d verdicts pending",
				quiet_cycles, pending_verdicts.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		frame_valid  = 1'b0;
		frame_byte   = '0;
		last_byte    = 1'b0;
		result_ready = 1'b0;
		hold_req     = 1'b0;
		rx_pace      = RX_ALWAYS;
		tx_gaps      = 1'b0;
		burst_left   = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		// no idling on either side, then uneven pacing on both sides
		test_random_traffic(32'h0000_0000, RX_ALWAYS, 1'b0, 140);
		test_random_traffic(32'hFFFF_FFFF, RX_RANDOM, 1'b1, 140);
		test_random_traffic(32'($urandom), RX_BURSTY, 1'b1, 140);
		test_random_traffic(32'($urandom), RX_RANDOM, 1'b1, 140);
		test_result_backpressure();
		drain_results();

		$display("ran %0d frames over %0d byte words, %0d verdicts checked, %0d address writes",
			frames_counted, words_sent, results_checked, configs_written);
		$display("arp %0d icmp %0d udp %0d tcp %0d other %0d | drops: eth %0d arp %0d type %0d",
			verdict_hits[VERDICT_ARP], verdict_hits[VERDICT_ICMP], verdict_hits[VERDICT_UDP],
			verdict_hits[VERDICT_TCP], verdict_hits[VERDICT_OTHER], drop_hits[DROP_SHORT_ETH],
			drop_hits[DROP_SHORT_ARP], drop_hits[DROP_ETHERTYPE]);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/eirc_pkg.sv
hdl/eirc_front.sv
hdl/eirc_fifo.sv
hdl/eirc_back.sv
hdl/eth_ipv4_rx_classifier_top.sv
sim/eth_ipv4_rx_classifier_top_tb.sv
